### rtl/sskl_pkg.sv
// shared types and constants for the scrambled setting key lookup unit
package sskl_pkg;

   localparam int NAME_CHARS = 8;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_NAME_CHARS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_NAME_LENGTH  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCRAMBLE_SEED    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE_LENGTH = 8'd3;

   localparam logic [63:0] KEY_NAME_CHARS_RESET   = 64'd0;
   localparam logic [3:0]  KEY_NAME_LENGTH_RESET  = 4'd4;
   localparam logic [31:0] SCRAMBLE_SEED_RESET    = 32'h73B5_DBFA;
   localparam logic [8:0]  MAX_VALUE_LENGTH_RESET = 9'd4;

   localparam logic [7:0] CASE_MASK = 8'hDF;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef enum logic [1:0] {
      PHASE_SEARCH = 2'd0,
      PHASE_VALUE  = 2'd1,
      PHASE_DONE   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [63:0] key_name_chars;
      logic [3:0]  key_name_length;
      logic [31:0] scramble_seed;
      logic [8:0]  max_value_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0] value_byte;
      logic       byte_valid;
      logic       lookup_done;
      logic       lookup_found;
   } rsp_type;

endpackage

### rtl/sskl_if.sv
// channel interfaces: text byte requests, lookup responses, register writes
interface sskl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_byte;

   modport source (output valid, output text_byte, output first_byte, input ready);
   modport sink (input valid, input text_byte, input first_byte, output ready);
endinterface

interface sskl_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] value_byte;
   logic       byte_valid;
   logic       lookup_done;
   logic       lookup_found;

   modport source (output valid, output value_byte, output byte_valid,
                   output lookup_done, output lookup_found, input ready);
   modport sink (input valid, input value_byte, input byte_valid,
                 input lookup_done, input lookup_found, output ready);
endinterface

interface sskl_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [63:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/sskl_csr.sv
// configuration register file
module sskl_csr
   import sskl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sskl_csr_if.sink   csr_if,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en = csr_if.valid;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_name_chars   <= KEY_NAME_CHARS_RESET;
         cfg_ff.key_name_length  <= KEY_NAME_LENGTH_RESET;
         cfg_ff.scramble_seed    <= SCRAMBLE_SEED_RESET;
         cfg_ff.max_value_length <= MAX_VALUE_LENGTH_RESET;
      end else if (wr_en) begin
         case (csr_if.index)
            CSR_KEY_NAME_CHARS:   cfg_ff.key_name_chars   <= csr_if.data;
            CSR_KEY_NAME_LENGTH:  cfg_ff.key_name_length  <= csr_if.data[3:0];
            CSR_SCRAMBLE_SEED:    cfg_ff.scramble_seed    <= csr_if.data[31:0];
            CSR_MAX_VALUE_LENGTH: cfg_ff.max_value_length <= csr_if.data[8:0];
            default: ;
         endcase
      end
   end

endmodule

### rtl/sskl_core.sv
// per-byte unscramble, key match and value extraction with result register
module sskl_core
   import sskl_pkg::*;
#(
   parameter int TEXT_BYTES = 256
)(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   sskl_req_if.sink   req_if,
   sskl_rsp_if.source rsp_if
);

   localparam int POS_W = (TEXT_BYTES > 1) ? $clog2(TEXT_BYTES) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_BYTES - 1);

   logic [31:0]      key_ff, key_in, key_eff;
   logic [POS_W-1:0] pos_ff, pos_in, pos_eff;
   logic [3:0]       match_ff, match_in, match_eff;
   phase_type        phase_ff, phase_in, phase_eff;
   logic [8:0]       wc_ff, wc_in, wc_eff;
   logic             out_valid_ff;
   rsp_type          out_ff, out_in;
   logic             out_load;

   logic             accept;
   logic [7:0]       raw;
   logic [7:0]       plain;
   logic [7:0]       val;
   logic             last;
   logic [3:0]       name_len;
   logic [7:0]       name_char;
   logic [9:0]       wc_inc;
   logic             limit_hit;

   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      raw       = req_if.text_byte;
      key_eff   = req_if.first_byte ? cfg.scramble_seed : key_ff;
      pos_eff   = req_if.first_byte ? '0 : pos_ff;
      match_eff = req_if.first_byte ? 4'd0 : match_ff;
      phase_eff = req_if.first_byte ? PHASE_SEARCH : phase_ff;
      wc_eff    = req_if.first_byte ? 9'd0 : wc_ff;

      plain = (raw != 8'd0) ? (raw ^ key_eff[7:0]) : 8'd0;
      last  = (pos_eff == POS_LAST);
      name_len = (cfg.key_name_length > 4'(NAME_CHARS)) ? 4'(NAME_CHARS)
                                                         : cfg.key_name_length;
      name_char = cfg.key_name_chars[{match_eff[2:0], 3'b000} +: 8];
      val = ((plain == CHAR_CR) || (plain == CHAR_LF)) ? 8'd0 : plain;
      wc_inc = {1'b0, wc_eff} + 10'd1;
      limit_hit = 1'b0;

      key_in   = key_eff;
      pos_in   = pos_eff;
      match_in = match_eff;
      phase_in = phase_eff;
      wc_in    = wc_eff;
      out_load = 1'b0;
      out_in   = '0;

      case (phase_eff)
         PHASE_SEARCH: begin
            if (raw != 8'd0) begin
               if (match_eff >= name_len) begin
                  if (plain == CHAR_EQUALS) begin
                     phase_in = PHASE_VALUE;
                  end else begin
                     match_in = 4'd0;
                  end
               end else if (((plain ^ name_char) & CASE_MASK) == 8'd0) begin
                  match_in = match_eff + 4'd1;
               end else begin
                  match_in = 4'd0;
               end
            end
            limit_hit = (phase_in == PHASE_VALUE) && (wc_eff >= cfg.max_value_length);
            if (last || limit_hit) begin
               phase_in = PHASE_DONE;
               out_load = 1'b1;
               out_in.lookup_done = 1'b1;
            end
            key_in = {key_eff[30:0], key_eff[31]};
            pos_in = last ? pos_eff : pos_eff + POS_W'(1);
         end
         PHASE_VALUE: begin
            wc_in = wc_inc[8:0];
            out_load = 1'b1;
            out_in.byte_valid = 1'b1;
            out_in.value_byte = val;
            if (val == 8'd0) begin
               phase_in = PHASE_DONE;
               out_in.lookup_done = 1'b1;
               out_in.lookup_found = 1'b1;
            end else if (last || (wc_inc >= {1'b0, cfg.max_value_length})) begin
               phase_in = PHASE_DONE;
               out_in.lookup_done = 1'b1;
            end
            key_in = {key_eff[30:0], key_eff[31]};
            pos_in = last ? pos_eff : pos_eff + POS_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= SCRAMBLE_SEED_RESET;
         pos_ff       <= '0;
         match_ff     <= 4'd0;
         phase_ff     <= PHASE_SEARCH;
         wc_ff        <= 9'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            key_ff   <= key_in;
            pos_ff   <= pos_in;
            match_ff <= match_in;
            phase_ff <= phase_in;
            wc_ff    <= wc_in;
         end
         if (accept && out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.value_byte   = out_ff.value_byte;
   assign rsp_if.byte_valid   = out_ff.byte_valid;
   assign rsp_if.lookup_done  = out_ff.lookup_done;
   assign rsp_if.lookup_found = out_ff.lookup_found;

   // a held result blocks new bytes
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_if.ready |-> !req_if.ready)
      else $error("request taken while result stalled");

   // a result without a value byte only ends the lookup
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.byte_valid || out_ff.lookup_done))
      else $error("empty result beat");

   // success is the terminator beat
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.lookup_found |->
         out_ff.lookup_done && out_ff.byte_valid && (out_ff.value_byte == 8'd0))
      else $error("malformed success beat");

   // position counter saturates at the last byte
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("byte position past end of text");

endmodule

### rtl/scrambled_setting_key_lookup_unit.sv
// top level of the scrambled setting key lookup unit
// a result beat is registered and appears in the cycle after the byte that causes it is taken
// throughput: one text byte per cycle unless a held result stalls, set by the single result register,
//    which refills in the same cycle it drains
// reset: synchronous, clears lookup state and loads register defaults (seed 0x73B5DBFA)
module scrambled_setting_key_lookup_unit
   import sskl_pkg::*;
#(
   parameter int TEXT_BYTES = 256
)(
   input  logic       clock,
   input  logic       reset,
   sskl_req_if.sink   req_if,
   sskl_rsp_if.source rsp_if,
   sskl_csr_if.sink   csr_if
);

   cfg_type cfg;

   sskl_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   sskl_core #(
      .TEXT_BYTES (TEXT_BYTES)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

endmodule
